// File: hdl/nfd_pkg.sv
// Shared constants, controller types and helper functions for the navigation frame deframer.
package nfd_pkg;

  localparam logic [7:0] HDR0 = 8'h55;
  localparam logic [7:0] HDR1 = 8'hAA;
  localparam logic [7:0] HDR2 = 8'h4C;

  localparam int FRAME_LEN = 80;
  localparam int POS_W     = $clog2(FRAME_LEN);

  localparam logic [POS_W-1:0] POS_HDR0    = POS_W'(0);
  localparam logic [POS_W-1:0] POS_HDR1    = POS_W'(1);
  localparam logic [POS_W-1:0] POS_HDR2    = POS_W'(2);
  localparam logic [POS_W-1:0] POS_BODY    = POS_W'(3);
  localparam logic [POS_W-1:0] TIME_FIRST  = POS_W'(3);
  localparam logic [POS_W-1:0] TIME_LAST   = POS_W'(6);
  localparam logic [POS_W-1:0] POS_LAST    = POS_W'(FRAME_LEN - 1);
  localparam logic [POS_W-1:0] WORD0_ADDR  = POS_W'(11);
  localparam logic [POS_W-1:0] SHORT_ADDR  = POS_W'(77);
  localparam logic [POS_W-1:0] AUX_ADDR    = POS_W'(7);

  localparam int WORD_W   = 32;
  localparam int INDEX_W  = 5;
  localparam int SLOT_W   = 5;
  localparam int TDATA_W  = 40;

  localparam logic [INDEX_W-1:0] SHORT_WORD = INDEX_W'(15);
  localparam logic [INDEX_W-1:0] AUX_WORD   = INDEX_W'(16);

  localparam int TIME_BITS = 32;

  // quotient by 200 = (count >> 3) / 25, taken by multiplying with ceil(2**34 / 25)
  localparam int QUO_PROD_W = 42;
  localparam int QUO_SHIFT  = 34;
  localparam logic [QUO_PROD_W-1:0] RECIP_25 = QUO_PROD_W'(687194768);

  localparam logic [7:0] TIME_MOD     = 8'd200;
  // remainder of 2**32 by 200: a negative count is a multiple of 200 iff its raw bits leave this
  localparam logic [7:0] NEG_ZERO_REM = 8'd96;
  localparam int         SLOT_STEP    = 10;
  localparam int         MAX_SLOT     = 17;
  localparam logic [SLOT_W-1:0] NO_SLOT = SLOT_W'(18);

  localparam logic [1:0] BYTE_LAST_WORD  = 2'd3;
  localparam logic [1:0] BYTE_LAST_SHORT = 2'd1;

  typedef enum logic [2:0] {
    ST_RX,
    ST_MOD,
    ST_START,
    ST_RD,
    ST_DAT,
    ST_EMIT
  } ctl_state_t;

  typedef struct packed {
    logic rx_en;
    logic mod_step;
    logic word_start;
    logic rd_issue;
    logic rd_shift;
    logic emit_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic frame_good;
    logic mod_last;
    logic byte_last;
    logic out_free;
    logic word_last;
  } ctl_sts_t;

  function automatic logic [POS_W-1:0] word_addr(input logic [INDEX_W-1:0] idx);
    logic [POS_W-1:0] addr;
    if (idx == AUX_WORD) begin
      addr = AUX_ADDR;
    end else if (idx == SHORT_WORD) begin
      addr = SHORT_ADDR;
    end else begin
      addr = WORD0_ADDR + POS_W'({idx, 2'b00});
    end
    return addr;
  endfunction

  function automatic logic [SLOT_W-1:0] aux_slot_of(input logic neg, input logic [7:0] rem);
    logic [SLOT_W-1:0] slot;
    slot = NO_SLOT;
    if (neg) begin
      if (rem == NEG_ZERO_REM) begin
        slot = '0;
      end
    end else begin
      for (int k = 0; k <= MAX_SLOT; k++) begin
        if (rem == 8'(k * SLOT_STEP)) begin
          slot = SLOT_W'(k);
        end
      end
    end
    return slot;
  endfunction

endpackage

// File: hdl/nav_frame_deframer.sv
// Top level of the navigation frame deframer: controller plus datapath.
// Hunts the byte stream for the header 55 AA 4C, stores the 80-byte frame and checks the
// additive sum of bytes 2..78 against byte 79. While a frame is being received one byte beat
// is taken per cycle. After a good frame the input stalls while the time count (bytes 3..6)
// is reduced modulo 200 by a reciprocal-multiply unit and the 17 words are read back from
// the frame store one byte at a time (read, then shift into the word), and while output
// backpressure holds a finished word. Bad frames emit nothing.
// Out beats: tdata[31:0] word value, tdata[36:32] aux slot (18 = none), tuser word index,
// tlast on word 16.
module nav_frame_deframer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] rx_byte
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [nfd_pkg::TDATA_W-1:0] out_tdata,  // [31:0] word_value, [36:32] aux_slot
  output logic [nfd_pkg::INDEX_W-1:0] out_tuser,  // [4:0] word_index
  output logic                        out_tlast   // last_word
);

  nfd_pkg::ctl_cmd_t cmd;
  nfd_pkg::ctl_sts_t sts;

  nfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .sts       (sts),
    .cmd       (cmd)
  );

  nfd_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

  assign in_tready = cmd.rx_en;

endmodule

// File: hdl/nfd_ctrl.sv
// Sequencing state machine: receive, time-count reduction, word readout and emission.
module nfd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  nfd_pkg::ctl_sts_t  sts,
  output nfd_pkg::ctl_cmd_t  cmd
);

  nfd_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nfd_pkg::ST_RX;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      nfd_pkg::ST_RX: begin
        cmd.rx_en = 1'b1;
        if (in_tvalid && sts.frame_good) begin
          state_nxt = nfd_pkg::ST_MOD;
        end
      end
      nfd_pkg::ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) begin
          state_nxt = nfd_pkg::ST_START;
        end
      end
      nfd_pkg::ST_START: begin
        cmd.word_start = 1'b1;
        state_nxt      = nfd_pkg::ST_RD;
      end
      nfd_pkg::ST_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = nfd_pkg::ST_DAT;
      end
      nfd_pkg::ST_DAT: begin
        cmd.rd_shift = 1'b1;
        state_nxt    = sts.byte_last ? nfd_pkg::ST_EMIT : nfd_pkg::ST_RD;
      end
      nfd_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          state_nxt     = sts.word_last ? nfd_pkg::ST_RX : nfd_pkg::ST_START;
        end
      end
      default: begin
        state_nxt = nfd_pkg::ST_RX;
      end
    endcase
  end

endmodule

// File: hdl/nfd_datapath.sv
// Frame position and checksum tracking, frame store, modulo unit, word assembly and output register.
module nfd_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic [7:0]                  in_tdata,   // [7:0] rx_byte
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [nfd_pkg::TDATA_W-1:0] out_tdata,  // [31:0] word_value, [36:32] aux_slot
  output logic [nfd_pkg::INDEX_W-1:0] out_tuser,  // [4:0] word_index
  output logic                        out_tlast,  // last_word
  input  nfd_pkg::ctl_cmd_t           cmd,
  output nfd_pkg::ctl_sts_t           sts
);

  logic [7:0] frame_mem [nfd_pkg::FRAME_LEN];

  logic [nfd_pkg::POS_W-1:0]      pos_r, pos_nxt;
  logic [7:0]                     sum_r, sum_nxt;
  logic [nfd_pkg::TIME_BITS-1:0]  time_r;
  logic                           mod_cnt_r;
  logic [nfd_pkg::QUO_PROD_W-1:0] quo_prod;
  logic [7:0]                     quo_r;
  logic [7:0]                     rem_r;
  logic [nfd_pkg::INDEX_W-1:0]    word_idx_r;
  logic [nfd_pkg::POS_W-1:0]      rd_addr_r;
  logic [1:0]                     byte_cnt_r;
  logic [7:0]                     rd_data_r;
  logic [nfd_pkg::WORD_W-1:0]     asm_r;
  logic [nfd_pkg::WORD_W-1:0]     word_val;
  logic                           in_acc;
  logic                           frame_end;
  logic                           out_valid_r;
  logic [nfd_pkg::TDATA_W-1:0]    out_data_r;
  logic [nfd_pkg::INDEX_W-1:0]    out_user_r;
  logic                           out_last_r;

  assign in_acc    = in_tvalid && cmd.rx_en;
  assign frame_end = in_acc && (pos_r == nfd_pkg::POS_LAST);

  always_comb begin
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    if (in_acc) begin
      priority if (pos_r == nfd_pkg::POS_HDR0) begin
        pos_nxt = (in_tdata == nfd_pkg::HDR0) ? nfd_pkg::POS_HDR1 : nfd_pkg::POS_HDR0;
      end else if (pos_r == nfd_pkg::POS_HDR1 || pos_r == nfd_pkg::POS_HDR2) begin
        if (pos_r == nfd_pkg::POS_HDR1 && in_tdata == nfd_pkg::HDR1) begin
          pos_nxt = nfd_pkg::POS_HDR2;
        end else if (pos_r == nfd_pkg::POS_HDR2 && in_tdata == nfd_pkg::HDR2) begin
          pos_nxt = nfd_pkg::POS_BODY;
          sum_nxt = in_tdata;
        end else if (in_tdata == nfd_pkg::HDR0) begin
          pos_nxt = nfd_pkg::POS_HDR1;
        end else begin
          pos_nxt = nfd_pkg::POS_HDR0;
        end
      end else if (pos_r == nfd_pkg::POS_LAST) begin
        pos_nxt = nfd_pkg::POS_HDR0;
        sum_nxt = '0;
      end else begin
        pos_nxt = pos_r + 1'b1;
        sum_nxt = sum_r + in_tdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= nfd_pkg::POS_HDR0;
      sum_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
    end
  end

  // frame store: one write port from the receive side, one registered read port
  always_ff @(posedge clk) begin
    if (in_acc) begin
      frame_mem[pos_r] <= in_tdata;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= frame_mem[rd_addr_r];
    end
  end

  // time count capture and remainder by 200: quotient low byte first, then subtract
  assign quo_prod = {{(nfd_pkg::QUO_PROD_W - nfd_pkg::TIME_BITS + 3){1'b0}},
                     time_r[nfd_pkg::TIME_BITS-1:3]} * nfd_pkg::RECIP_25;

  always_ff @(posedge clk) begin
    if (in_acc && pos_r >= nfd_pkg::TIME_FIRST && pos_r <= nfd_pkg::TIME_LAST) begin
      time_r <= {in_tdata, time_r[nfd_pkg::TIME_BITS-1:8]};
    end
    if (frame_end) begin
      mod_cnt_r <= 1'b0;
    end else if (cmd.mod_step) begin
      mod_cnt_r <= 1'b1;
      quo_r     <= quo_prod[nfd_pkg::QUO_PROD_W-1:nfd_pkg::QUO_SHIFT];
      rem_r     <= time_r[7:0] - quo_r * nfd_pkg::TIME_MOD;
    end
  end

  // word readout
  always_ff @(posedge clk) begin
    if (frame_end) begin
      word_idx_r <= '0;
    end else if (cmd.emit_load) begin
      word_idx_r <= word_idx_r + 1'b1;
    end
    if (cmd.word_start) begin
      rd_addr_r  <= nfd_pkg::word_addr(word_idx_r);
      byte_cnt_r <= '0;
    end else begin
      if (cmd.rd_issue) begin
        rd_addr_r <= rd_addr_r + 1'b1;
      end
      if (cmd.rd_shift) begin
        byte_cnt_r <= byte_cnt_r + 1'b1;
      end
    end
    if (cmd.rd_shift) begin
      asm_r <= {rd_data_r, asm_r[nfd_pkg::WORD_W-1:8]};
    end
  end

  assign word_val = (word_idx_r == nfd_pkg::SHORT_WORD)
                  ? {{16{asm_r[nfd_pkg::WORD_W-1]}}, asm_r[nfd_pkg::WORD_W-1:16]}
                  : asm_r;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_data_r <= {3'b000, nfd_pkg::aux_slot_of(time_r[nfd_pkg::TIME_BITS-1], rem_r),
                     word_val};
      out_user_r <= word_idx_r;
      out_last_r <= (word_idx_r == nfd_pkg::AUX_WORD);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  assign sts.frame_good = (pos_r == nfd_pkg::POS_LAST) && (in_tdata == sum_r);
  assign sts.mod_last   = mod_cnt_r;
  assign sts.byte_last  = (word_idx_r == nfd_pkg::SHORT_WORD)
                        ? (byte_cnt_r == nfd_pkg::BYTE_LAST_SHORT)
                        : (byte_cnt_r == nfd_pkg::BYTE_LAST_WORD);
  assign sts.out_free   = !out_valid_r || out_tready;
  assign sts.word_last  = (word_idx_r == nfd_pkg::AUX_WORD);

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_load |-> (!out_valid_r || out_tready))
    else $error("word loaded over an unaccepted beat");

  a_rd_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |-> (rd_addr_r <= nfd_pkg::POS_LAST))
    else $error("frame store read beyond frame");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    frame_end |=> (pos_r == nfd_pkg::POS_HDR0 && sum_r == '0))
    else $error("position or checksum not cleared after last byte");

  a_no_rx_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mod_step || cmd.rd_issue || cmd.rd_shift) |-> !cmd.rx_en)
    else $error("receive enabled during readout");

endmodule

// File: tb/sv/nav_frame_deframer_test.sv
// Self-checking testbench for nav_frame_deframer: header hunt, checksum, and word emission.
module nav_frame_deframer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TIME_AT     = int'(nfd_pkg::TIME_FIRST);
  localparam int SUM_FIRST   = int'(nfd_pkg::POS_HDR2);
  localparam int SUM_AT      = nfd_pkg::FRAME_LEN - 1;
  localparam int NUM_WORDS   = int'(nfd_pkg::AUX_WORD) + 1;
  localparam int HOLD_CYCLES = 600;

  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  typedef struct packed {
    logic [nfd_pkg::INDEX_W-1:0] word_idx;
    logic [nfd_pkg::WORD_W-1:0]  word_val;
    logic [nfd_pkg::SLOT_W-1:0]  slot;
    logic                        last_word;
  } frame_word_t;

  class frame_word_board;
    frame_word_t               expected_words[$];
    logic [nfd_pkg::POS_W-1:0] byte_pos;
    logic [7:0]                frame_sum;
    logic [7:0]                frame_bytes[nfd_pkg::FRAME_LEN];
    int                        failures;

    function new();
      byte_pos    = '0;
      frame_sum   = '0;
      failures    = 0;
      foreach (frame_bytes[i]) frame_bytes[i] = '0;
    endfunction

    function logic [31:0] word_at(int a);
      return {frame_bytes[a + 3], frame_bytes[a + 2], frame_bytes[a + 1], frame_bytes[a]};
    endfunction

    function logic [nfd_pkg::SLOT_W-1:0] slot_for(logic [31:0] tc);
      logic [31:0] r;
      if (tc[31]) begin
        r = (32'd0 - tc) % 32'd200;
        return (r == 32'd0) ? nfd_pkg::SLOT_W'(0) : nfd_pkg::NO_SLOT;
      end
      r = tc % 32'd200;
      if (r % 32'd10 == 32'd0 && r <= 32'd170) begin
        return nfd_pkg::SLOT_W'(r / 32'd10);
      end
      return nfd_pkg::NO_SLOT;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void note_byte(logic [7:0] b);
      logic [7:0]                 want;
      logic [nfd_pkg::SLOT_W-1:0] slot;
      frame_word_t                w;
      if (byte_pos <= nfd_pkg::POS_HDR2) begin
        want = (byte_pos == nfd_pkg::POS_HDR0) ? nfd_pkg::HDR0 :
               (byte_pos == nfd_pkg::POS_HDR1) ? nfd_pkg::HDR1 : nfd_pkg::HDR2;
        if (b == want) begin
          frame_bytes[byte_pos] = b;
          if (byte_pos == nfd_pkg::POS_HDR2) frame_sum = b;
          byte_pos = byte_pos + 1'b1;
        end else if (b == nfd_pkg::HDR0) begin
          frame_bytes[0] = b;
          byte_pos = nfd_pkg::POS_HDR1;
        end else begin
          byte_pos = nfd_pkg::POS_HDR0;
        end
        return;
      end
      frame_bytes[byte_pos] = b;
      if (byte_pos < nfd_pkg::POS_LAST) begin
        frame_sum = frame_sum + b;
        byte_pos  = byte_pos + 1'b1;
        return;
      end
      byte_pos = nfd_pkg::POS_HDR0;
      if (frame_sum == b) begin
        slot = slot_for(word_at(TIME_AT));
        for (int k = 0; k < NUM_WORDS; k++) begin
          w.word_idx  = nfd_pkg::INDEX_W'(k);
          w.slot      = slot;
          w.last_word = (w.word_idx == nfd_pkg::AUX_WORD);
          if (w.word_idx == nfd_pkg::AUX_WORD) begin
            w.word_val = word_at(int'(nfd_pkg::AUX_ADDR));
          end else if (w.word_idx == nfd_pkg::SHORT_WORD) begin
            w.word_val = {{16{frame_bytes[nfd_pkg::SHORT_ADDR + 1][7]}},
                          frame_bytes[nfd_pkg::SHORT_ADDR + 1],
                          frame_bytes[nfd_pkg::SHORT_ADDR]};
          end else begin
            w.word_val = word_at(int'(nfd_pkg::WORD0_ADDR) + 4 * k);
          end
          expected_words.push_back(w);
        end
      end
      frame_sum = '0;
    endfunction

    function void check_word(logic [nfd_pkg::INDEX_W-1:0] idx, logic [nfd_pkg::WORD_W-1:0] val,
                             logic [nfd_pkg::SLOT_W-1:0] slot, logic last_word);
      frame_word_t e;
      if (expected_words.size() == 0) begin
        $error("out beat with no word expected: word_index %0d word_value %h", idx, val);
        failures++;
        return;
      end
      e = expected_words.pop_front();
      if (idx !== e.word_idx) begin
        $error("word_index expected %0d got %0d", e.word_idx, idx);
        failures++;
      end
      if (val !== e.word_val) begin
        $error("word_value expected %h got %h", e.word_val, val);
        failures++;
      end
      if (slot !== e.slot) begin
        $error("aux_slot expected %0d got %0d", e.slot, slot);
        failures++;
      end
      if (last_word !== e.last_word) begin
        $error("last_word expected %0b got %0b", e.last_word, last_word);
        failures++;
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [7:0]                    in_tdata;
  logic                          out_tvalid;
  logic                          out_tready;
  logic [nfd_pkg::TDATA_W-1:0]   out_tdata;
  logic [nfd_pkg::INDEX_W-1:0]   out_tuser;
  logic                          out_tlast;

  frame_word_board sb;
  int  src_idle_pct;
  int  sink_idle_pct;
  bit  hold_req;
  bit  hold_done;

  nav_frame_deframer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_byte(in_tdata);
      if (out_tvalid && out_tready) begin
        sb.check_word(out_tuser, out_tdata[31:0], out_tdata[36:32], out_tlast);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [31:0] tc, input fill_t fill, input bit good);
    logic [7:0] fb[nfd_pkg::FRAME_LEN];
    logic [7:0] total;
    fb[0] = nfd_pkg::HDR0;
    fb[1] = nfd_pkg::HDR1;
    fb[2] = nfd_pkg::HDR2;
    for (int i = 3; i < SUM_AT; i++) begin
      case (fill)
        FILL_ZERO: fb[i] = 8'h00;
        FILL_ONES: fb[i] = 8'hFF;
        default:   fb[i] = 8'($urandom);
      endcase
    end
    for (int i = 0; i < 4; i++) fb[TIME_AT + i] = tc[8 * i +: 8];
    total = '0;
    for (int i = SUM_FIRST; i < SUM_AT; i++) total = total + fb[i];
    fb[SUM_AT] = good ? total : total + 8'($urandom_range(1, 255));
    for (int i = 0; i < nfd_pkg::FRAME_LEN; i++) send_byte(fb[i]);
  endtask

  initial begin
    sb            = new();
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    src_idle_pct  = 27;
    sink_idle_pct = 61;
    hold_req      = 1'b0;
    hold_done     = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_byte(nfd_pkg::HDR0);
    send_byte(8'h00);
    send_byte(nfd_pkg::HDR0);
    send_byte(nfd_pkg::HDR1);
    send_byte(8'h00);
    send_byte(nfd_pkg::HDR0);
    send_byte(nfd_pkg::HDR1);
    send_byte(nfd_pkg::HDR0);
    send_byte(nfd_pkg::HDR0);
    send_frame(32'hFFFF_FF38, FILL_ONES, 1'b1);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);

    src_idle_pct  = 61;
    sink_idle_pct = 27;
    send_frame(32'd170, FILL_RANDOM, 1'b1);
    in_tvalid <= 1'b0;
    while (sb.pending() > 8) @(negedge clk);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_req      = 1'b1;
    send_frame(32'hFFFF_FFF6, FILL_RANDOM, 1'b0);

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
